// ----- rtl/ggm_pkg.sv -----
// Package: AES-128 tables, round and key schedule functions, sequencer types.
package ggm_pkg;

  localparam int IDX_W = 20;
  localparam int IDX_SEL_W = 5;
  localparam int WORD_W = 64;
  localparam int BLK_W = 128;
  localparam int DEPTH_W = 5;
  localparam int REG_IDX_W = 2;
  localparam int NROUNDS = 10;

  typedef enum logic [1:0] {
    REG_LEFT_HIGH  = 2'd0,
    REG_LEFT_LOW   = 2'd1,
    REG_RIGHT_HIGH = 2'd2,
    REG_RIGHT_LOW  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BLK0,
    S_BLK1,
    S_OUT
  } state_t;

  typedef enum logic {
    ACT_EVAL      = 1'b0,
    ACT_CONSTRAIN = 1'b1
  } action_t;

  typedef struct packed {
    logic             start;
    logic [BLK_W-1:0] blk;
    logic [BLK_W-1:0] key;
  } core_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [BLK_W-1:0] result;
  } core_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 is the most significant byte
  function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] rk,
                                               input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] st,
                                                input logic [BLK_W-1:0] rk,
                                                input logic last);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [BLK_W-1:0] o;
    for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[r+4*c] = SBOX[s[r+4*((c+r)&3)]];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o ^ rk;
  endfunction

endpackage

// ----- rtl/ggm_if.sv -----
// Channel interfaces for requests and derived-key responses.
interface ggm_req_if import ggm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [WORD_W-1:0]  seed_word0;
  logic [WORD_W-1:0]  seed_word1;
  logic [WORD_W-1:0]  seed_word2;
  logic [WORD_W-1:0]  seed_word3;
  logic [DEPTH_W-1:0] tree_depth;
  logic [IDX_W-1:0]   leaf_index;
  modport source (output valid, action, seed_word0, seed_word1, seed_word2, seed_word3,
                  tree_depth, leaf_index, input ready);
  modport sink (input valid, action, seed_word0, seed_word1, seed_word2, seed_word3,
                tree_depth, leaf_index, output ready);
endinterface

interface ggm_rsp_if import ggm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  key_word0;
  logic [WORD_W-1:0]  key_word1;
  logic [WORD_W-1:0]  key_word2;
  logic [WORD_W-1:0]  key_word3;
  logic [DEPTH_W-1:0] depth_out;
  modport source (output valid, key_word0, key_word1, key_word2, key_word3, depth_out,
                  input ready);
  modport sink (input valid, key_word0, key_word1, key_word2, key_word3, depth_out,
                output ready);
endinterface

// ----- rtl/ggm_constrained_prf_aes.sv -----
// Top level: GGM-tree PRF sequencer over a shared iterative AES-128 core.
// Usage:
//   Write the four 64-bit key registers through cfg_we/cfg_index/cfg_data
//   while the block is idle. A request transaction on req carries the action,
//   a 256-bit seed, a depth and a leaf index; one response transaction on rsp
//   returns the derived 256-bit value and depth_out.
//   Each tree level is one decision in S_CHECK, then two AES blocks in
//   turn (start, ten rounds on the single round unit, done).
//   Response valid rises in S_OUT once the walk ends, L being the levels
//   walked (at most MAX_DEPTH).
//   One request is in flight at a time: req.ready is high only when idle.
//   The response holds in its output register until rsp.ready; a stalled
//   receiver simply keeps the block from taking the next request.
//   Reset clears the key registers to zero and returns the sequencer to idle.
module ggm_constrained_prf_aes import ggm_pkg::*; #(
  parameter int MAX_DEPTH = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  ggm_req_if.sink              req,
  ggm_rsp_if.source            rsp
);

  localparam int CW = $clog2(MAX_DEPTH + 1);

  state_t           state, state_next;
  logic [WORD_W-1:0] lk_hi, lk_lo, rk_hi, rk_lo;
  logic [255:0]     v;
  logic [CW-1:0]    cnt;
  logic [IDX_W-1:0] idx;
  action_t          act;
  logic             use_right;
  logic [DEPTH_W-1:0] dout;
  logic [CW-1:0]    pos;
  logic             cur_bit;
  core_cmd_t        cmd;
  core_sts_t        sts;

  ggm_aes_core u_core (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_hi <= '0;
      lk_lo <= '0;
      rk_hi <= '0;
      rk_lo <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEFT_HIGH:  lk_hi <= cfg_data;
        REG_LEFT_LOW:   lk_lo <= cfg_data;
        REG_RIGHT_HIGH: rk_hi <= cfg_data;
        REG_RIGHT_LOW:  rk_lo <= cfg_data;
      endcase
    end
  end

  assign pos     = cnt - CW'(1);
  assign cur_bit = (32'(pos) < IDX_W) ? idx[IDX_SEL_W'(pos)] : 1'b0;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.start  = 1'b0;
    cmd.blk    = v[255:128];
    cmd.key    = use_right ? {rk_hi, rk_lo} : {lk_hi, lk_lo};
    unique case (state)
      S_IDLE:  if (req.valid) state_next = S_CHECK;
      S_CHECK: begin
        priority if (cnt == '0) state_next = S_OUT;
        else if (act == ACT_CONSTRAIN && cur_bit) state_next = S_OUT;
        else state_next = S_BLK0;
      end
      S_BLK0: begin
        if (!sts.busy && !sts.done) cmd.start = 1'b1;
        if (sts.done) state_next = S_BLK1;
      end
      S_BLK1: begin
        cmd.blk = v[127:0] ^ v[255:128];
        if (!sts.busy && !sts.done) cmd.start = 1'b1;
        if (sts.done) state_next = S_CHECK;
      end
      S_OUT:   if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // block 0 start fires in the first BLK0 cycle; block 1 start in the first BLK1 cycle
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          v    <= {req.seed_word0, req.seed_word1, req.seed_word2, req.seed_word3};
          idx  <= req.leaf_index;
          act  <= action_t'(req.action);
          dout <= '0;
          if (req.action == ACT_CONSTRAIN) cnt <= CW'(MAX_DEPTH);
          else if (32'(req.tree_depth) > MAX_DEPTH) cnt <= CW'(MAX_DEPTH);
          else cnt <= CW'(req.tree_depth);
        end
      end
      S_CHECK: begin
        if (act == ACT_CONSTRAIN) dout <= DEPTH_W'(cnt);
        if (cnt != '0 && !(act == ACT_CONSTRAIN && cur_bit)) begin
          use_right <= (act == ACT_EVAL) && cur_bit;
          cnt       <= cnt - CW'(1);
        end
      end
      S_BLK0: if (sts.done) v[255:128] <= sts.result;
      S_BLK1: if (sts.done) v[127:0] <= sts.result;
      default: ;
    endcase
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = (state == S_OUT);
  assign rsp.key_word0 = v[255:192];
  assign rsp.key_word1 = v[191:128];
  assign rsp.key_word2 = v[127:64];
  assign rsp.key_word3 = v[63:0];
  assign rsp.depth_out = dout;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("request taken while response pending");
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state == S_CHECK) else $error("accept did not start walk");
  a_done_in_block: assert property (@(posedge clk) disable iff (rst)
    sts.done |-> (state == S_BLK0 || state == S_BLK1)) else $error("stray core done");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.key_word0) && $stable(dout))
    else $error("response changed under stall");

endmodule

// ----- rtl/ggm_aes_core.sv -----
// Iterative AES-128 encryptor: one round and one key-schedule step per cycle.
module ggm_aes_core import ggm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  core_cmd_t cmd,
  output core_sts_t sts
);

  logic [BLK_W-1:0] st;
  logic [BLK_W-1:0] rk;
  logic [3:0]       rnd;
  logic             run;
  logic             done;
  logic [BLK_W-1:0] rk_next;

  assign rk_next = key_step(rk, rcon(rnd));

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !run) begin
        run <= 1'b1;
        rnd <= 4'd1;
      end else if (run) begin
        rnd <= rnd + 4'd1;
        if (rnd == 4'(NROUNDS)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && !run) begin
      st <= cmd.blk ^ cmd.key;
      rk <= cmd.key;
    end else if (run) begin
      st <= aes_round(st, rk_next, rnd == 4'(NROUNDS));
      rk <= rk_next;
    end
  end

  assign sts.busy   = run;
  assign sts.done   = done;
  assign sts.result = st;

endmodule
